// File: rtl/ple_pkg.sv
// Shared types, codes and sizes for the positional list engine.
package ple_pkg;

    localparam int DEPTH = 32;
    localparam int CAP   = (DEPTH < 32) ? DEPTH : 32;
    localparam int IDX_W = (CAP > 1) ? $clog2(CAP) : 1;
    localparam int CNT_W = 6;

    localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAP);

    typedef logic signed [31:0] t_word;
    typedef logic [IDX_W-1:0]   t_idx;
    typedef logic [CNT_W-1:0]   t_cnt;

    localparam logic [3:0] F_ADD_FRONT  = 4'd0;
    localparam logic [3:0] F_ADD_BACK   = 4'd1;
    localparam logic [3:0] F_REM_FRONT  = 4'd2;
    localparam logic [3:0] F_REM_BACK   = 4'd3;
    localparam logic [3:0] F_INS_BEFORE = 4'd4;
    localparam logic [3:0] F_INS_AFTER  = 4'd5;
    localparam logic [3:0] F_REM_AT     = 4'd6;
    localparam logic [3:0] F_REVERSE    = 4'd7;
    localparam logic [3:0] F_DUMP       = 4'd8;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_EMPTY  = 2'd1;
    localparam logic [1:0] ST_BADPOS = 2'd2;
    localparam logic [1:0] ST_FULL   = 2'd3;

    typedef enum logic [1:0] {
        C_HOLD,
        C_INSERT,
        C_REMOVE,
        C_MOVE
    } t_cell_op;

    typedef enum logic [1:0] {
        S_IDLE,
        S_REV,
        S_DUMP
    } t_state;

    typedef struct packed {
        t_cell_op op;
        t_idx     idx;
        t_word    value;
        t_word    head;
    } t_cell_ctrl;

endpackage

// File: rtl/ple_cell.sv
// One list slot: holds an element and takes a neighbor, the new value or the head.
module ple_cell (
    input  logic                i_clk,
    input  ple_pkg::t_cell_ctrl i_ctrl,
    input  ple_pkg::t_idx       i_index,
    input  ple_pkg::t_word      i_left,
    input  ple_pkg::t_word      i_right,
    output ple_pkg::t_word      o_data
);

    ple_pkg::t_word r_data;
    ple_pkg::t_word n_data;

    always_comb begin
        n_data = r_data;
        unique case (i_ctrl.op)
            ple_pkg::C_HOLD: begin
                n_data = r_data;
            end
            ple_pkg::C_INSERT: begin
                if (i_index == i_ctrl.idx) begin
                    n_data = i_ctrl.value;
                end else if (i_index > i_ctrl.idx) begin
                    n_data = i_left;
                end
            end
            ple_pkg::C_REMOVE: begin
                if (i_index >= i_ctrl.idx) begin
                    n_data = i_right;
                end
            end
            ple_pkg::C_MOVE: begin
                if (i_index < i_ctrl.idx) begin
                    n_data = i_right;
                end else if (i_index == i_ctrl.idx) begin
                    n_data = i_ctrl.head;
                end
            end
            default: begin
                n_data = r_data;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;

endmodule

// File: rtl/positional_list_engine.sv
// Top level of the positional list engine: request decode, sequencer and cell chain.
//
// The list lives in a row of 32 cells, element 1 in the first cell. Add, insert and
// remove requests act on every cell at once, each shifting toward or away from its
// neighbor (remove back only lowers the count), and the result goes into an output
// register, so the next request is accepted as soon as that register is free. Reverse
// of n elements (n >= 2) moves the head cell to the end of the unreversed part at each
// step; only its last step waits on the output register. Dump gives one element per
// cycle while the output register is free, rotating the head to the back so the list
// is unchanged at the end. No request is accepted during a reverse or a dump.
module positional_list_engine (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [3:0]  i_func,
    input  logic signed [31:0] i_value,
    input  logic [7:0]  i_position,
    output logic        o_valid,
    input  logic        i_ready,
    output logic signed [31:0] o_element,
    output logic [5:0]  o_count,
    output logic [1:0]  o_status,
    output logic        o_last
);

    ple_pkg::t_state r_state;
    ple_pkg::t_state n_state;
    ple_pkg::t_cnt   r_occ;
    ple_pkg::t_cnt   n_occ;
    ple_pkg::t_idx   r_k;
    ple_pkg::t_idx   n_k;

    logic           r_out_valid;
    logic           n_out_valid;
    ple_pkg::t_word r_element;
    ple_pkg::t_word n_element;
    ple_pkg::t_cnt  r_count;
    ple_pkg::t_cnt  n_count;
    logic [1:0]     r_status;
    logic [1:0]     n_status;
    logic           r_last;
    logic           n_last;

    ple_pkg::t_cell_ctrl w_ctrl;
    ple_pkg::t_word      w_data [ple_pkg::CAP];

    logic               w_slot_free;
    logic               w_take;
    logic               w_posok;
    logic               w_full;
    logic               w_empty;
    logic [1:0]         w_st;
    ple_pkg::t_cell_op  w_op;
    ple_pkg::t_idx      w_idx;
    ple_pkg::t_cnt      w_cnt;
    logic               w_emit;
    logic               w_go_rev;
    logic               w_go_dump;
    ple_pkg::t_cnt      w_occ_m1;
    ple_pkg::t_cnt      w_occ_m2;
    logic               w_rev_last;
    logic               w_dump_last;

    assign w_slot_free = !r_out_valid || i_ready;
    assign o_ready     = (r_state == ple_pkg::S_IDLE) && w_slot_free;
    assign w_take      = i_valid && o_ready;

    assign w_posok  = (i_position != 8'd0) && (i_position <= {2'b00, r_occ});
    assign w_full   = (r_occ >= ple_pkg::CAP_CNT);
    assign w_empty  = (r_occ == '0);
    assign w_occ_m1 = r_occ - ple_pkg::CNT_W'(1);
    assign w_occ_m2 = r_occ - ple_pkg::CNT_W'(2);
    assign w_rev_last  = (ple_pkg::CNT_W'(r_k) == w_occ_m2);
    assign w_dump_last = (ple_pkg::CNT_W'(r_k) == w_occ_m1);

    // request decode
    always_comb begin
        w_st      = ple_pkg::ST_OK;
        w_op      = ple_pkg::C_HOLD;
        w_idx     = '0;
        w_cnt     = r_occ;
        w_emit    = 1'b1;
        w_go_rev  = 1'b0;
        w_go_dump = 1'b0;
        unique case (i_func)
            ple_pkg::F_ADD_FRONT, ple_pkg::F_ADD_BACK: begin
                if (w_full) begin
                    w_st = ple_pkg::ST_FULL;
                end else begin
                    w_op  = ple_pkg::C_INSERT;
                    w_idx = (i_func == ple_pkg::F_ADD_FRONT) ? '0
                                                              : r_occ[ple_pkg::IDX_W-1:0];
                    w_cnt = r_occ + ple_pkg::CNT_W'(1);
                end
            end
            ple_pkg::F_INS_BEFORE, ple_pkg::F_INS_AFTER: begin
                if (!w_posok) begin
                    w_st = ple_pkg::ST_BADPOS;
                end else if (w_full) begin
                    w_st = ple_pkg::ST_FULL;
                end else begin
                    w_op  = ple_pkg::C_INSERT;
                    w_idx = (i_func == ple_pkg::F_INS_BEFORE)
                          ? ple_pkg::IDX_W'(i_position - 8'd1)
                          : i_position[ple_pkg::IDX_W-1:0];
                    w_cnt = r_occ + ple_pkg::CNT_W'(1);
                end
            end
            ple_pkg::F_REM_FRONT, ple_pkg::F_REM_BACK: begin
                if (w_empty) begin
                    w_st = ple_pkg::ST_EMPTY;
                end else begin
                    w_op  = (i_func == ple_pkg::F_REM_FRONT) ? ple_pkg::C_REMOVE
                                                             : ple_pkg::C_HOLD;
                    w_cnt = w_occ_m1;
                end
            end
            ple_pkg::F_REM_AT: begin
                if (w_empty) begin
                    w_st = ple_pkg::ST_EMPTY;
                end else if (!w_posok) begin
                    w_st = ple_pkg::ST_BADPOS;
                end else begin
                    w_op  = ple_pkg::C_REMOVE;
                    w_idx = ple_pkg::IDX_W'(i_position - 8'd1);
                    w_cnt = w_occ_m1;
                end
            end
            ple_pkg::F_REVERSE: begin
                if (w_empty) begin
                    w_st = ple_pkg::ST_EMPTY;
                end else if (r_occ != ple_pkg::CNT_W'(1)) begin
                    w_emit   = 1'b0;
                    w_go_rev = 1'b1;
                end
            end
            ple_pkg::F_DUMP: begin
                if (w_empty) begin
                    w_st = ple_pkg::ST_EMPTY;
                end else begin
                    w_emit    = 1'b0;
                    w_go_dump = 1'b1;
                end
            end
            default: begin
                w_st = ple_pkg::ST_OK;
            end
        endcase
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ple_pkg::S_IDLE: begin
                if (w_take && w_go_rev) begin
                    n_state = ple_pkg::S_REV;
                end else if (w_take && w_go_dump) begin
                    n_state = ple_pkg::S_DUMP;
                end
            end
            ple_pkg::S_REV: begin
                if (w_rev_last && w_slot_free) begin
                    n_state = ple_pkg::S_IDLE;
                end
            end
            ple_pkg::S_DUMP: begin
                if (w_dump_last && w_slot_free) begin
                    n_state = ple_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = ple_pkg::S_IDLE;
            end
        endcase
    end

    // cell control, count and result register
    always_comb begin
        w_ctrl.op    = ple_pkg::C_HOLD;
        w_ctrl.idx   = '0;
        w_ctrl.value = i_value;
        w_ctrl.head  = w_data[0];
        n_occ        = r_occ;
        n_k          = r_k;
        n_out_valid  = r_out_valid && !i_ready;
        n_element    = r_element;
        n_count      = r_count;
        n_status     = r_status;
        n_last       = r_last;
        unique case (r_state)
            ple_pkg::S_IDLE: begin
                if (w_take) begin
                    w_ctrl.op  = w_op;
                    w_ctrl.idx = w_idx;
                    n_occ      = w_cnt;
                    n_k        = '0;
                    if (w_emit) begin
                        n_out_valid = 1'b1;
                        n_element   = '0;
                        n_count     = w_cnt;
                        n_status    = w_st;
                        n_last      = 1'b1;
                    end
                end
            end
            ple_pkg::S_REV: begin
                if (!w_rev_last || w_slot_free) begin
                    w_ctrl.op  = ple_pkg::C_MOVE;
                    w_ctrl.idx = ple_pkg::IDX_W'(w_occ_m1 - ple_pkg::CNT_W'(r_k));
                    n_k        = r_k + ple_pkg::IDX_W'(1);
                end
                if (w_rev_last && w_slot_free) begin
                    n_out_valid = 1'b1;
                    n_element   = '0;
                    n_count     = r_occ;
                    n_status    = ple_pkg::ST_OK;
                    n_last      = 1'b1;
                end
            end
            ple_pkg::S_DUMP: begin
                if (w_slot_free) begin
                    w_ctrl.op   = ple_pkg::C_MOVE;
                    w_ctrl.idx  = w_occ_m1[ple_pkg::IDX_W-1:0];
                    n_k         = r_k + ple_pkg::IDX_W'(1);
                    n_out_valid = 1'b1;
                    n_element   = w_data[0];
                    n_count     = r_occ;
                    n_status    = ple_pkg::ST_OK;
                    n_last      = w_dump_last;
                end
            end
            default: begin
                w_ctrl.op = ple_pkg::C_HOLD;
            end
        endcase
    end

    genvar g;
    generate
        for (g = 0; g < ple_pkg::CAP; g++) begin : g_cell
            ple_pkg::t_word w_left;
            ple_pkg::t_word w_right;
            if (g == 0) begin : g_first
                assign w_left = '0;
            end else begin : g_mid_l
                assign w_left = w_data[g-1];
            end
            if (g == ple_pkg::CAP - 1) begin : g_end
                assign w_right = '0;
            end else begin : g_mid_r
                assign w_right = w_data[g+1];
            end
            ple_cell u_cell (
                .i_clk   (i_clk),
                .i_ctrl  (w_ctrl),
                .i_index (ple_pkg::IDX_W'(g)),
                .i_left  (w_left),
                .i_right (w_right),
                .o_data  (w_data[g])
            );
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ple_pkg::S_IDLE;
            r_occ       <= '0;
            r_k         <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_occ       <= n_occ;
            r_k         <= n_k;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_element <= n_element;
        r_count   <= n_count;
        r_status  <= n_status;
        r_last    <= n_last;
    end

    assign o_valid   = r_out_valid;
    assign o_element = r_element;
    assign o_count   = r_count;
    assign o_status  = r_status;
    assign o_last    = r_last;

    a_occ_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_occ <= ple_pkg::CAP_CNT)
        else $error("occupancy above capacity");

    a_dump_keeps_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ple_pkg::S_DUMP) |=> (r_occ == $past(r_occ)))
        else $error("count changed during dump");

    a_mid_result_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_last) |-> (o_status == ple_pkg::ST_OK && o_count != 6'd0))
        else $error("non-final result is not a dump element");

    a_busy_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ple_pkg::S_IDLE) |-> !o_ready)
        else $error("request accepted during reverse or dump");

endmodule

// File: sim/positional_list_engine_tb.sv
// Testbench for the positional list engine, checked against a shadow list.
`timescale 1ns / 1ps

module positional_list_engine_tb;

    localparam logic [3:0] F_UNUSED_LO = 4'd9;
    localparam logic [3:0] F_UNUSED_HI = 4'd15;

    typedef struct {
        ple_pkg::t_word element;
        ple_pkg::t_cnt  count;
        logic [1:0]     status;
        logic           last;
    } t_list_result;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_valid;
    logic              o_ready;
    logic [3:0]        i_func;
    logic signed [31:0] i_value;
    logic [7:0]        i_position;
    logic              o_valid;
    logic              i_ready;
    logic signed [31:0] o_element;
    logic [5:0]        o_count;
    logic [1:0]        o_status;
    logic              o_last;

    ple_pkg::t_word list_mem [ple_pkg::CAP];
    int             list_len;
    t_list_result   pending_results [$];
    int             err_count;
    bit             tx_steady;
    bit             rx_steady;
    int             hold_off_cycles;

    positional_list_engine DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_func     (i_func),
        .i_value    (i_value),
        .i_position (i_position),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_element  (o_element),
        .o_count    (o_count),
        .o_status   (o_status),
        .o_last     (o_last)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #25_000_000;
        $display("simulation failed");
        $finish;
    end

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        err_count++;
    endtask

    function automatic void push_result(input ple_pkg::t_word element,
                                        input logic [1:0] status, input logic last);
        t_list_result r;
        r.element = element;
        r.count   = ple_pkg::t_cnt'(list_len);
        r.status  = status;
        r.last    = last;
        pending_results.push_back(r);
    endfunction

    function automatic logic [1:0] store_at(input int idx, input ple_pkg::t_word value);
        if (list_len >= ple_pkg::CAP) return ple_pkg::ST_FULL;
        for (int i = list_len; i > idx; i--) list_mem[i] = list_mem[i-1];
        list_mem[idx] = value;
        list_len++;
        return ple_pkg::ST_OK;
    endfunction

    function automatic void drop_at(input int idx);
        for (int i = idx; i + 1 < list_len; i++) list_mem[i] = list_mem[i+1];
        list_len--;
    endfunction

    function automatic void predict_request(input logic [3:0] func,
                                            input ple_pkg::t_word value,
                                            input logic [7:0] pos);
        logic [1:0]     st;
        bit             pos_ok;
        ple_pkg::t_word tmp;
        st = ple_pkg::ST_OK;
        pos_ok = (pos >= 1) && (pos <= list_len);
        case (func)
            ple_pkg::F_ADD_FRONT:  st = store_at(0, value);
            ple_pkg::F_ADD_BACK:   st = store_at(list_len, value);
            ple_pkg::F_REM_FRONT: begin
                if (list_len == 0) st = ple_pkg::ST_EMPTY;
                else drop_at(0);
            end
            ple_pkg::F_REM_BACK: begin
                if (list_len == 0) st = ple_pkg::ST_EMPTY;
                else list_len--;
            end
            ple_pkg::F_INS_BEFORE: st = pos_ok ? store_at(pos - 1, value) : ple_pkg::ST_BADPOS;
            ple_pkg::F_INS_AFTER:  st = pos_ok ? store_at(pos, value) : ple_pkg::ST_BADPOS;
            ple_pkg::F_REM_AT: begin
                if (list_len == 0) st = ple_pkg::ST_EMPTY;
                else if (!pos_ok) st = ple_pkg::ST_BADPOS;
                else drop_at(pos - 1);
            end
            ple_pkg::F_REVERSE: begin
                if (list_len == 0) begin
                    st = ple_pkg::ST_EMPTY;
                end else begin
                    for (int i = 0; i < list_len / 2; i++) begin
                        tmp = list_mem[i];
                        list_mem[i] = list_mem[list_len-1-i];
                        list_mem[list_len-1-i] = tmp;
                    end
                end
            end
            ple_pkg::F_DUMP: begin
                if (list_len == 0) begin
                    push_result('0, ple_pkg::ST_EMPTY, 1'b1);
                end else begin
                    for (int i = 0; i < list_len; i++)
                        push_result(list_mem[i], ple_pkg::ST_OK, (i == list_len - 1));
                end
                return;
            end
            default: ;
        endcase
        push_result('0, st, 1'b1);
    endfunction

    task automatic send_item(input logic [3:0] func, input ple_pkg::t_word value,
                             input logic [7:0] pos);
        int gap;
        int r;
        r = $urandom_range(0, 99);
        if (tx_steady || r < 55) gap = 0;
        else if (r < 90) gap = $urandom_range(1, 3);
        else gap = $urandom_range(8, 30);
        @(negedge i_clk);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid    <= 1'b1;
        i_func     <= func;
        i_value    <= value;
        i_position <= pos;
        do @(posedge i_clk); while (!o_ready);
        predict_request(func, value, pos);
    endtask

    task automatic wait_results_drained();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    function automatic ple_pkg::t_word pick_value();
        int r;
        r = $urandom_range(0, 99);
        if (r < 5) return 32'sh7fff_ffff;
        if (r < 10) return 32'sh8000_0000;
        if (r < 13) return '0;
        if (r < 15) return -1;
        return ple_pkg::t_word'($urandom);
    endfunction

    function automatic logic [7:0] pick_position();
        int r;
        r = $urandom_range(0, 9);
        if (r < 7 && list_len > 0) return 8'($urandom_range(1, list_len));
        if (r == 7) return '0;
        if (r == 8) return 8'(list_len + 1);
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic logic [3:0] pick_func(input int add_pct);
        int r;
        r = $urandom_range(0, 99);
        if (r < 3) return 4'($urandom_range(F_UNUSED_LO, F_UNUSED_HI));
        if (r < 3 + add_pct) begin
            case ($urandom_range(0, 3))
                0: return ple_pkg::F_ADD_FRONT;
                1: return ple_pkg::F_ADD_BACK;
                2: return ple_pkg::F_INS_BEFORE;
                default: return ple_pkg::F_INS_AFTER;
            endcase
        end
        if (r < 10 + add_pct) return ple_pkg::F_REVERSE;
        if (r < 20 + add_pct) return ple_pkg::F_DUMP;
        case ($urandom_range(0, 2))
            0: return ple_pkg::F_REM_FRONT;
            1: return ple_pkg::F_REM_BACK;
            default: return ple_pkg::F_REM_AT;
        endcase
    endfunction

    task automatic send_random(input int n, input int add_pct);
        for (int k = 0; k < n; k++)
            send_item(pick_func(add_pct), pick_value(), pick_position());
    endtask

    task automatic test_empty_list();
        send_item(ple_pkg::F_REM_FRONT,  '0, 8'd0);
        send_item(ple_pkg::F_REM_BACK,   '0, 8'd0);
        send_item(ple_pkg::F_REM_AT,     '0, 8'd1);
        send_item(ple_pkg::F_REVERSE,    '0, 8'd0);
        send_item(ple_pkg::F_DUMP,       '0, 8'd0);
        send_item(ple_pkg::F_INS_BEFORE, 32'sd11, 8'd1);
        send_item(ple_pkg::F_INS_AFTER,  32'sd12, 8'd0);
        send_item(F_UNUSED_HI,           -1, 8'hff);
        send_item(F_UNUSED_LO,           '0, 8'd0);
    endtask

    task automatic test_edge_values();
        send_item(ple_pkg::F_ADD_FRONT,  32'sh7fff_ffff, 8'd0);
        send_item(ple_pkg::F_ADD_BACK,   32'sh8000_0000, 8'd0);
        send_item(ple_pkg::F_INS_BEFORE, '0, 8'd1);
        send_item(ple_pkg::F_INS_AFTER,  -1, 8'd3);
        send_item(ple_pkg::F_INS_BEFORE, 32'sd5, 8'd255);
        send_item(ple_pkg::F_REM_AT,     '0, 8'd0);
        send_item(ple_pkg::F_REM_AT,     '0, 8'd5);
        send_item(ple_pkg::F_DUMP,       '0, 8'd0);
        send_item(ple_pkg::F_REVERSE,    '0, 8'd0);
        send_item(ple_pkg::F_DUMP,       '0, 8'd0);
        send_item(ple_pkg::F_REM_AT,     '0, 8'd1);
        send_item(ple_pkg::F_REM_AT,     '0, 8'd3);
        send_item(4'd12,                 '0, 8'd0);
        send_item(ple_pkg::F_REM_BACK,   '0, 8'd0);
        send_item(ple_pkg::F_DUMP,       '0, 8'd0);
        send_item(ple_pkg::F_REM_FRONT,  '0, 8'd0);
        send_item(ple_pkg::F_ADD_BACK,   32'sd5, 8'd0);
        send_item(ple_pkg::F_REVERSE,    '0, 8'd0);
        send_item(ple_pkg::F_REM_AT,     '0, 8'd1);
        send_item(ple_pkg::F_DUMP,       '0, 8'd0);
    endtask

    task automatic test_full_list();
        tx_steady = 1'b1;
        rx_steady = 1'b1;
        while (list_len < ple_pkg::CAP) send_item(ple_pkg::F_ADD_BACK, pick_value(), 8'd0);
        send_item(ple_pkg::F_ADD_FRONT,  32'sd1, 8'd0);
        send_item(ple_pkg::F_INS_BEFORE, 32'sd2, 8'd1);
        send_item(ple_pkg::F_INS_AFTER,  32'sd3, 8'(ple_pkg::CAP));
        send_item(ple_pkg::F_INS_AFTER,  32'sd4, 8'd0);
        send_item(ple_pkg::F_INS_BEFORE, 32'sd5, 8'(ple_pkg::CAP + 1));
        send_item(ple_pkg::F_DUMP,       '0, 8'd0);
        send_item(ple_pkg::F_REVERSE,    '0, 8'd0);
        send_item(ple_pkg::F_DUMP,       '0, 8'd0);
        send_item(ple_pkg::F_REM_AT,     '0, 8'(ple_pkg::CAP));
        send_item(ple_pkg::F_REM_AT,     '0, 8'd1);
        tx_steady = 1'b0;
        rx_steady = 1'b0;
    endtask

    task automatic test_output_hold_off();
        tx_steady = 1'b1;
        hold_off_cycles = 300;
        send_item(ple_pkg::F_DUMP, '0, 8'd0);
        send_random(23, 45);
        tx_steady = 1'b0;
    endtask

    task automatic test_random_mix();
        send_random(90, 70);
        send_random(60, 45);
        wait_results_drained();
        send_random(80, 25);
        tx_steady = 1'b1;
        rx_steady = 1'b1;
        send_random(40, 50);
        tx_steady = 1'b0;
        rx_steady = 1'b0;
        send_random(80, 55);
    endtask

    always @(posedge i_clk) begin : check_results
        t_list_result want;
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_results.size() == 0) begin
                report_mismatch("result with nothing expected", o_element, 0);
            end else begin
                want = pending_results.pop_front();
                if (o_element !== want.element) report_mismatch("element", o_element, want.element);
                if (o_count !== want.count) report_mismatch("count", o_count, want.count);
                if (o_status !== want.status) report_mismatch("status", o_status, want.status);
                if (o_last !== want.last) report_mismatch("last", o_last, want.last);
            end
        end
    end

    initial begin : drive_ready
        int gap_left;
        int r;
        gap_left = 0;
        forever begin
            @(negedge i_clk);
            if (hold_off_cycles > 0) begin
                i_ready <= 1'b0;
                hold_off_cycles--;
            end else if (rx_steady) begin
                i_ready <= 1'b1;
            end else if (gap_left > 0) begin
                i_ready <= 1'b0;
                gap_left--;
            end else begin
                r = $urandom_range(0, 99);
                if (r < 65) begin
                    i_ready <= 1'b1;
                end else if (r < 92) begin
                    i_ready <= 1'b0;
                    gap_left = $urandom_range(0, 2);
                end else begin
                    i_ready <= 1'b0;
                    gap_left = $urandom_range(10, 40);
                end
            end
        end
    end

    initial begin
        i_rst_n    = 1'b0;
        i_valid    = 1'b0;
        i_func     = ple_pkg::F_ADD_FRONT;
        i_value    = '0;
        i_position = '0;
        i_ready    = 1'b0;
        list_len   = 0;
        err_count  = 0;
        tx_steady  = 1'b0;
        rx_steady  = 1'b0;
        hold_off_cycles = 0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_empty_list();
        test_edge_values();
        test_full_list();
        test_output_hold_off();
        test_random_mix();

        wait_results_drained();
        repeat (64) @(posedge i_clk);
        if (err_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
